@@ sv/trr_pkg.sv @@
// shared types, codes and reset values for the tftp read receiver
package trr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_DONE  = 2'd2,
        PH_ABORT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PACKET  = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_RESEND = 2'd1,
        ERR_SERVER = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        REG_RESEND_LIMIT = 2'd0,
        REG_SERVER_PORT  = 2'd1,
        REG_INIT_ADDR    = 2'd2,
        REG_FULL_LENGTH  = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ERROR = 16'd5;
    localparam logic [10:0] HDR_BYTES = 11'd4;

    localparam logic [3:0]  RST_RESEND_LIMIT = 4'd3;
    localparam logic [15:0] RST_SERVER_PORT  = 16'd69;
    localparam logic [31:0] RST_INIT_ADDR    = 32'hFFFF_FFFF;
    localparam logic [10:0] RST_FULL_LENGTH  = 11'd516;

    typedef struct packed {
        logic [3:0]  resend_limit;
        logic [15:0] server_port;
        logic [31:0] initial_address;
        logic [10:0] full_packet_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] packet_length;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [31:0] source_address;
        logic [15:0] source_port;
    } item_t;

    typedef struct packed {
        logic        send_request;
        logic        send_ack;
        logic [15:0] ack_number;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic        deliver_payload;
        logic [10:0] payload_length;
        logic        transfer_done;
        logic        error_flag;
        logic [1:0]  error_kind;
    } result_t;

endpackage

@@ sv/trr_cfg_regs.sv @@
// configuration register bank of the tftp read receiver
module trr_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output trr_pkg::cfg_t      cfg
);

    trr_pkg::cfg_t cfg_reg;
    trr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (trr_pkg::cfg_idx_t'(cfg_index))
                trr_pkg::REG_RESEND_LIMIT: cfg_next.resend_limit = cfg_data[3:0];
                trr_pkg::REG_SERVER_PORT:  cfg_next.server_port = cfg_data[15:0];
                trr_pkg::REG_INIT_ADDR:    cfg_next.initial_address = cfg_data;
                trr_pkg::REG_FULL_LENGTH:  cfg_next.full_packet_length = cfg_data[10:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resend_limit       <= trr_pkg::RST_RESEND_LIMIT;
            cfg_reg.server_port        <= trr_pkg::RST_SERVER_PORT;
            cfg_reg.initial_address    <= trr_pkg::RST_INIT_ADDR;
            cfg_reg.full_packet_length <= trr_pkg::RST_FULL_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/trr_engine.sv @@
// transfer state and per-request decision logic of the tftp read receiver
module trr_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trr_pkg::cfg_t        cfg,
    input  trr_pkg::item_t       item,
    input  logic                 step,
    output trr_pkg::result_t     result
);

    trr_pkg::phase_t phase_reg;
    trr_pkg::phase_t phase_next;
    logic [15:0]     expected_reg;
    logic [15:0]     expected_next;
    logic [31:0]     locked_addr_reg;
    logic [31:0]     locked_addr_next;
    logic [15:0]     locked_port_reg;
    logic [15:0]     locked_port_next;
    logic [15:0]     last_block_reg;
    logic [15:0]     last_block_next;
    logic            last_short_reg;
    logic            last_short_next;
    logic [4:0]      resend_reg;
    logic [4:0]      resend_next;

    logic        is_start;
    logic        is_timeout;
    logic        is_packet;
    logic [4:0]  resend_inc;
    logic        too_many;
    logic        exp_is_one;
    logic        exp_above_one;
    logic        is_short;
    logic        peer_ok;
    logic        pkt_ok;
    logic        err_pkt;
    logic        data_pkt;
    logic        in_seq;
    logic        dup_blk;
    logic        acked;
    logic        deliver;

    // decode
    always_comb
    begin
        is_start      = (trr_pkg::op_t'(item.op) == trr_pkg::OP_START);
        is_timeout    = (phase_reg == trr_pkg::PH_WAIT)
                        && (trr_pkg::op_t'(item.op) == trr_pkg::OP_TIMEOUT);
        is_packet     = (phase_reg == trr_pkg::PH_WAIT)
                        && (trr_pkg::op_t'(item.op) == trr_pkg::OP_PACKET);
        resend_inc    = resend_reg + 5'd1;
        too_many      = resend_inc > {1'b0, cfg.resend_limit};
        exp_is_one    = (expected_reg == 16'd1);
        exp_above_one = (expected_reg > 16'd1);
        is_short      = item.packet_length < cfg.full_packet_length;
        peer_ok       = (item.source_address == locked_addr_reg)
                        && (item.source_port == locked_port_reg);
        pkt_ok        = is_packet && (item.packet_length >= trr_pkg::HDR_BYTES)
                        && !(exp_above_one && !peer_ok);
        err_pkt       = pkt_ok && (item.packet_opcode == trr_pkg::OPC_ERROR);
        data_pkt      = pkt_ok && (item.packet_opcode == trr_pkg::OPC_DATA);
        in_seq        = (item.packet_block == expected_reg);
        dup_blk       = (item.packet_block == (expected_reg - 16'd1));
        acked         = data_pkt && (in_seq || dup_blk);
        deliver       = data_pkt && in_seq;
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        expected_next    = expected_reg;
        locked_addr_next = locked_addr_reg;
        locked_port_next = locked_port_reg;
        last_block_next  = last_block_reg;
        last_short_next  = last_short_reg;
        resend_next      = resend_reg;
        if (is_start)
        begin
            phase_next       = trr_pkg::PH_WAIT;
            expected_next    = 16'd1;
            locked_addr_next = cfg.initial_address;
            locked_port_next = cfg.server_port;
            last_block_next  = 16'd0;
            last_short_next  = 1'b0;
            resend_next      = 5'd0;
        end
        else if (is_timeout)
        begin
            resend_next = resend_inc;
            if (too_many)
                phase_next = trr_pkg::PH_ABORT;
            else if (!exp_is_one && last_short_reg)
                phase_next = trr_pkg::PH_DONE;
        end
        else if (is_packet)
        begin
            last_short_next = is_short;
            if (err_pkt)
                phase_next = trr_pkg::PH_ABORT;
            if (data_pkt)
                last_block_next = item.packet_block;
            if (deliver)
            begin
                expected_next = expected_reg + 16'd1;
                if (exp_is_one)
                begin
                    locked_addr_next = item.source_address;
                    locked_port_next = item.source_port;
                end
            end
            if (acked)
            begin
                resend_next = 5'd0;
                if (is_short)
                    phase_next = trr_pkg::PH_DONE;
            end
        end
    end

    // result
    always_comb
    begin
        result = '0;
        if (is_start)
        begin
            result.send_request = 1'b1;
            result.dest_address = cfg.initial_address;
            result.dest_port    = cfg.server_port;
        end
        else if (is_timeout)
        begin
            if (too_many)
            begin
                result.error_flag = 1'b1;
                result.error_kind = trr_pkg::ERR_RESEND;
            end
            else if (exp_is_one)
            begin
                result.send_request = 1'b1;
                result.dest_address = locked_addr_reg;
                result.dest_port    = locked_port_reg;
            end
            else
            begin
                result.send_ack      = 1'b1;
                result.ack_number    = last_block_reg;
                result.dest_address  = locked_addr_reg;
                result.dest_port     = locked_port_reg;
                result.transfer_done = last_short_reg;
            end
        end
        else if (err_pkt)
        begin
            result.error_flag = 1'b1;
            result.error_kind = trr_pkg::ERR_SERVER;
        end
        else if (acked)
        begin
            result.send_ack      = 1'b1;
            result.ack_number    = item.packet_block;
            result.dest_address  = locked_addr_next;
            result.dest_port     = locked_port_next;
            result.transfer_done = is_short;
            if (deliver)
            begin
                result.deliver_payload = 1'b1;
                result.payload_length  = item.packet_length - trr_pkg::HDR_BYTES;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= trr_pkg::PH_IDLE;
            expected_reg    <= 16'd0;
            locked_addr_reg <= 32'd0;
            locked_port_reg <= 16'd0;
            last_block_reg  <= 16'd0;
            last_short_reg  <= 1'b0;
            resend_reg      <= 5'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            expected_reg    <= expected_next;
            locked_addr_reg <= locked_addr_next;
            locked_port_reg <= locked_port_next;
            last_block_reg  <= last_block_next;
            last_short_reg  <= last_short_next;
            resend_reg      <= resend_next;
        end
    end

endmodule

@@ sv/tftp_read_receiver_unit.sv @@
// top level of the tftp read receiver: request register, engine, result register
//
//  channel | signals                          | direction | width of payload
//  in      | in_valid, in_ready, op .. port   | into      | 93 bits
//  out     | out_valid, out_ready, send_request .. error_kind | out of | 82 bits
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into | 2 + 32 bits
//
//  request register, then result register; one request per cycle while not stalled
//  the engine sits between the registers and updates its state as the result loads
//  rst_n clears the state to idle and cfg registers to defaults; no clearing pass
//  a stalled result holds the pipe; in_ready falls only when both stages are full
//  and out_ready is low
//  cfg_ready is always high
module tftp_read_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [10:0] packet_length,
    input  logic [15:0] packet_opcode,
    input  logic [15:0] packet_block,
    input  logic [31:0] source_address,
    input  logic [15:0] source_port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_request,
    output logic        send_ack,
    output logic [15:0] ack_number,
    output logic [31:0] dest_address,
    output logic [15:0] dest_port,
    output logic        deliver_payload,
    output logic [10:0] payload_length,
    output logic        transfer_done,
    output logic        error_flag,
    output logic [1:0]  error_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    trr_pkg::cfg_t    cfg;
    trr_pkg::item_t   item_reg;
    trr_pkg::item_t   item_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    trr_pkg::result_t result_reg;
    trr_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             step;

    trr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trr_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .step   (step),
        .result (result_next)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        item_next = item_reg;
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
            item_next.op             = op;
            item_next.packet_length  = packet_length;
            item_next.packet_opcode  = packet_opcode;
            item_next.packet_block   = packet_block;
            item_next.source_address = source_address;
            item_next.source_port    = source_port;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (step)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign send_request    = result_reg.send_request;
    assign send_ack        = result_reg.send_ack;
    assign ack_number      = result_reg.ack_number;
    assign dest_address    = result_reg.dest_address;
    assign dest_port       = result_reg.dest_port;
    assign deliver_payload = result_reg.deliver_payload;
    assign payload_length  = result_reg.payload_length;
    assign transfer_done   = result_reg.transfer_done;
    assign error_flag      = result_reg.error_flag;
    assign error_kind      = result_reg.error_kind;

`ifndef SYNTHESIS
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(send_request && send_ack))
        else $error("request and ack issued together");

    a_done_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (transfer_done || deliver_payload) |-> send_ack)
        else $error("completion or payload without ack");

    a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_flag == (error_kind != trr_pkg::ERR_NONE)))
        else $error("error flag and kind disagree");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> !send_request && !send_ack && !deliver_payload)
        else $error("abort carries a command");
`endif

endmodule
